### design/modbus_rtu_write_sequencer_defines.svh
// Assertion macros for the Modbus RTU write sequencer
`ifndef MODBUS_RTU_WRITE_SEQUENCER_DEFINES_SVH
`define MODBUS_RTU_WRITE_SEQUENCER_DEFINES_SVH

`ifndef SYNTH
`define MSQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define MSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MSQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define MSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### design/msq_pkg.sv
`default_nettype none

package msq_pkg;

    localparam logic [3:0]  REPLY_BYTES = 4'd8;
    localparam logic [3:0]  RX_MAX      = 4'hF;
    localparam logic [15:0] TICK_MAX    = 16'hFFFF;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FUNC_WRITE_MULTI = 8'h10;
    localparam logic [7:0] QTY_ONE          = 8'h01;
    localparam logic [7:0] BYTES_ONE        = 8'h02;
    localparam logic [7:0] QTY_TWO          = 8'h02;
    localparam logic [7:0] BYTES_TWO        = 8'h04;

    // data bytes before the CRC
    localparam logic [3:0] LEN_DATA_ONE = 4'd9;
    localparam logic [3:0] LEN_DATA_TWO = 4'd11;

    localparam logic [7:0]  SLAVE_ADDR_RST = 8'd173;
    localparam logic [15:0] MODE_REG_RST   = 16'd32101;
    localparam logic [15:0] MODE_VAL_RST   = 16'd1;
    localparam logic [15:0] CUR_REG_RST    = 16'd32107;
    localparam logic [31:0] CUR_VAL_RST    = 32'd30;
    localparam logic [15:0] TIMEOUT_RST    = 16'd600;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_TIMEOUT1 = 2'd1;
    localparam logic [1:0] ERR_TIMEOUT2 = 2'd2;

    typedef enum logic [1:0] {
        OP_SCAN = 2'd0,
        OP_TICK = 2'd1,
        OP_RX   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        CFG_SLAVE_ADDR = 3'd0,
        CFG_MODE_REG   = 3'd1,
        CFG_MODE_VAL   = 3'd2,
        CFG_CUR_REG    = 3'd3,
        CFG_CUR_VAL    = 3'd4,
        CFG_TIMEOUT    = 3'd5
    } t_cfg_idx;

    typedef enum logic [5:0] {
        SEQ_IDLE   = 6'b000001,
        SEQ_SEND1  = 6'b000010,
        SEQ_WAIT1  = 6'b000100,
        SEQ_SEND2  = 6'b001000,
        SEQ_WAIT2  = 6'b010000,
        SEQ_FINISH = 6'b100000
    } t_seq;

    typedef enum logic [3:0] {
        FR_IDLE  = 4'b0001,
        FR_LOAD  = 4'b0010,
        FR_SHIFT = 4'b0100,
        FR_EMIT  = 4'b1000
    } t_fr_phase;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic [1:0] error;
    } t_status;

    typedef struct packed {
        logic start;
        logic second;
    } t_frame_req;

endpackage

`default_nettype wire

### design/msq_if.sv
`default_nettype none

interface msq_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic       execute;

    modport source (output valid, output op, output execute, input ready);
    modport sink   (input valid, input op, input execute, output ready);
endinterface

interface msq_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       run_last;
    logic       busy_res;
    logic       done_res;
    logic [1:0] error_code;

    modport source (output valid, output tx_valid, output tx_byte, output run_last,
                    output busy_res, output done_res, output error_code, input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input run_last,
                    input busy_res, input done_res, input error_code, output ready);
endinterface

interface msq_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/msq_ctrl.sv
`default_nettype none

module msq_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [1:0]          i_op,
    input  wire logic                i_execute,
    input  wire logic [15:0]         i_timeout_ms,
    output msq_pkg::t_frame_req      o_req,
    output msq_pkg::t_status         o_cur,
    output msq_pkg::t_status         o_nxt
);

    msq_pkg::t_seq r_state, n_state;
    logic          r_latch, n_latch;
    logic [15:0]   r_tick,  n_tick;
    logic [3:0]    r_rx,    n_rx;
    logic          r_busy,  n_busy;
    logic          r_done,  n_done;
    logic [1:0]    r_err,   n_err;

    always_comb begin
        n_state = r_state;
        n_latch = r_latch;
        n_tick  = r_tick;
        n_rx    = r_rx;
        n_busy  = r_busy;
        n_done  = r_done;
        n_err   = r_err;
        o_req   = '0;
        case (i_op)
            msq_pkg::OP_TICK: begin
                if (r_tick != msq_pkg::TICK_MAX) n_tick = r_tick + 16'd1;
            end
            msq_pkg::OP_RX: begin
                if (r_rx != msq_pkg::RX_MAX) n_rx = r_rx + 4'd1;
            end
            msq_pkg::OP_SCAN: begin
                if (i_execute && !r_latch) begin
                    n_latch = 1'b1;
                    n_state = msq_pkg::SEQ_SEND1;
                    n_busy  = 1'b1;
                    n_done  = 1'b0;
                    n_err   = msq_pkg::ERR_NONE;
                end
                case (n_state)
                    msq_pkg::SEQ_IDLE: begin
                        n_busy = 1'b0;
                        if (!i_execute) n_latch = 1'b0;
                    end
                    msq_pkg::SEQ_SEND1, msq_pkg::SEQ_SEND2: begin
                        o_req.start  = 1'b1;
                        o_req.second = (n_state == msq_pkg::SEQ_SEND2);
                        n_rx         = '0;
                        n_tick       = '0;
                        n_state      = (n_state == msq_pkg::SEQ_SEND2) ?
                                       msq_pkg::SEQ_WAIT2 : msq_pkg::SEQ_WAIT1;
                    end
                    msq_pkg::SEQ_WAIT1: begin
                        if (r_rx >= msq_pkg::REPLY_BYTES) begin
                            n_state = msq_pkg::SEQ_SEND2;
                        end else if (r_tick > i_timeout_ms) begin
                            n_err   = msq_pkg::ERR_TIMEOUT1;
                            n_state = msq_pkg::SEQ_FINISH;
                        end
                    end
                    msq_pkg::SEQ_WAIT2: begin
                        if (r_rx >= msq_pkg::REPLY_BYTES) begin
                            n_done  = 1'b1;
                            n_err   = msq_pkg::ERR_NONE;
                            n_state = msq_pkg::SEQ_FINISH;
                        end else if (r_tick > i_timeout_ms) begin
                            n_err   = msq_pkg::ERR_TIMEOUT2;
                            n_state = msq_pkg::SEQ_FINISH;
                        end
                    end
                    msq_pkg::SEQ_FINISH: begin
                        n_busy = 1'b0;
                        if (!i_execute) begin
                            n_latch = 1'b0;
                            n_state = msq_pkg::SEQ_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msq_pkg::SEQ_IDLE;
            r_latch <= 1'b0;
            r_tick  <= '0;
            r_rx    <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_err   <= msq_pkg::ERR_NONE;
        end else if (i_accept) begin
            r_state <= n_state;
            r_latch <= n_latch;
            r_tick  <= n_tick;
            r_rx    <= n_rx;
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_err   <= n_err;
        end
    end

    assign o_cur = '{busy: r_busy, done: r_done, error: r_err};
    assign o_nxt = '{busy: n_busy, done: n_done, error: n_err};

endmodule

`default_nettype wire

### design/msq_frame.sv
`default_nettype none

module msq_frame (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_second,
    input  wire logic [7:0]  i_slave_addr,
    input  wire logic [15:0] i_mode_reg,
    input  wire logic [15:0] i_mode_val,
    input  wire logic [15:0] i_cur_reg,
    input  wire logic [31:0] i_cur_val,
    input  wire logic        i_out_free,
    output logic             o_active,
    output logic             o_emit,
    output logic [7:0]       o_byte,
    output logic             o_last
);

    msq_pkg::t_fr_phase r_phase, n_phase;
    logic        r_second, n_second;
    logic [3:0]  r_idx,    n_idx;
    logic [2:0]  r_bit,    n_bit;
    logic [15:0] r_crc,    n_crc;
    logic [7:0]  r_byte,   n_byte;

    logic [3:0]  w_data_len;
    logic [3:0]  w_total;
    logic [7:0]  w_data;
    logic [15:0] w_reg;

    assign w_data_len = r_second ? msq_pkg::LEN_DATA_TWO : msq_pkg::LEN_DATA_ONE;
    assign w_total    = w_data_len + 4'd2;
    assign w_reg      = r_second ? i_cur_reg : i_mode_reg;

    always_comb begin
        case (r_idx)
            4'd0:    w_data = i_slave_addr;
            4'd1:    w_data = msq_pkg::FUNC_WRITE_MULTI;
            4'd2:    w_data = w_reg[15:8];
            4'd3:    w_data = w_reg[7:0];
            4'd4:    w_data = 8'h00;
            4'd5:    w_data = r_second ? msq_pkg::QTY_TWO : msq_pkg::QTY_ONE;
            4'd6:    w_data = r_second ? msq_pkg::BYTES_TWO : msq_pkg::BYTES_ONE;
            4'd7:    w_data = r_second ? i_cur_val[31:24] : i_mode_val[15:8];
            4'd8:    w_data = r_second ? i_cur_val[23:16] : i_mode_val[7:0];
            4'd9:    w_data = i_cur_val[15:8];
            4'd10:   w_data = i_cur_val[7:0];
            default: w_data = 8'h00;
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_second = r_second;
        n_idx    = r_idx;
        n_bit    = r_bit;
        n_crc    = r_crc;
        n_byte   = r_byte;
        case (r_phase)
            msq_pkg::FR_IDLE: begin
                if (i_start) begin
                    n_second = i_second;
                    n_idx    = '0;
                    n_crc    = msq_pkg::CRC_INIT;
                    n_phase  = msq_pkg::FR_LOAD;
                end
            end
            msq_pkg::FR_LOAD: begin
                if (r_idx < w_data_len) begin
                    n_byte  = w_data;
                    n_crc   = r_crc ^ {8'h00, w_data};
                    n_bit   = '0;
                    n_phase = msq_pkg::FR_SHIFT;
                end else begin
                    n_byte  = (r_idx == w_data_len) ? r_crc[7:0] : r_crc[15:8];
                    n_phase = msq_pkg::FR_EMIT;
                end
            end
            msq_pkg::FR_SHIFT: begin
                // one CRC bit per cycle
                n_crc = r_crc[0] ? ({1'b0, r_crc[15:1]} ^ msq_pkg::CRC_POLY)
                                 : {1'b0, r_crc[15:1]};
                n_bit = r_bit + 3'd1;
                if (r_bit == 3'd7) n_phase = msq_pkg::FR_EMIT;
            end
            msq_pkg::FR_EMIT: begin
                if (i_out_free) begin
                    if (o_last) begin
                        n_phase = msq_pkg::FR_IDLE;
                    end else begin
                        n_idx   = r_idx + 4'd1;
                        n_phase = msq_pkg::FR_LOAD;
                    end
                end
            end
            default: n_phase = msq_pkg::FR_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= msq_pkg::FR_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_second <= n_second;
        r_idx    <= n_idx;
        r_bit    <= n_bit;
        r_crc    <= n_crc;
        r_byte   <= n_byte;
    end

    assign o_active = (r_phase != msq_pkg::FR_IDLE);
    assign o_emit   = (r_phase == msq_pkg::FR_EMIT);
    assign o_byte   = r_byte;
    assign o_last   = (r_idx == w_total - 4'd1);

endmodule

`default_nettype wire

### design/modbus_rtu_write_sequencer.sv
// A status-only item is loaded into the output register when it is accepted.
// A frame item takes each data byte through load, 8 serial CRC steps and emit, and
// each CRC byte through load and emit: 11 bytes for the first frame, 13 for the second.
// The next item is accepted once the frame has ended and the output register is free.
// Synchronous active-low reset: sequencer idle, counters and flags cleared,
// configuration registers back to their defaults.
`default_nettype none
`include "modbus_rtu_write_sequencer_defines.svh"

module modbus_rtu_write_sequencer (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    msq_in_if.sink        i_in,
    msq_cfg_if.sink       i_cfg,
    msq_out_if.source     o_out
);

    logic [7:0]  r_slave_addr;
    logic [15:0] r_mode_reg;
    logic [15:0] r_mode_val;
    logic [15:0] r_cur_reg;
    logic [31:0] r_cur_val;
    logic [15:0] r_timeout;

    logic        r_out_valid;
    logic        r_tx_valid;
    logic [7:0]  r_tx_byte;
    logic        r_run_last;
    msq_pkg::t_status r_status;

    msq_pkg::t_frame_req w_req;
    msq_pkg::t_status    w_cur;
    msq_pkg::t_status    w_nxt;

    logic       w_out_free;
    logic       w_in_ready;
    logic       w_in_acc;
    logic       w_frame_start;
    logic       w_frame_active;
    logic       w_frame_emit;
    logic [7:0] w_frame_byte;
    logic       w_frame_last;
    logic       w_emit_load;
    logic       w_stat_load;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= msq_pkg::SLAVE_ADDR_RST;
            r_mode_reg   <= msq_pkg::MODE_REG_RST;
            r_mode_val   <= msq_pkg::MODE_VAL_RST;
            r_cur_reg    <= msq_pkg::CUR_REG_RST;
            r_cur_val    <= msq_pkg::CUR_VAL_RST;
            r_timeout    <= msq_pkg::TIMEOUT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                msq_pkg::CFG_SLAVE_ADDR: r_slave_addr <= i_cfg.data[7:0];
                msq_pkg::CFG_MODE_REG:   r_mode_reg   <= i_cfg.data[15:0];
                msq_pkg::CFG_MODE_VAL:   r_mode_val   <= i_cfg.data[15:0];
                msq_pkg::CFG_CUR_REG:    r_cur_reg    <= i_cfg.data[15:0];
                msq_pkg::CFG_CUR_VAL:    r_cur_val    <= i_cfg.data;
                msq_pkg::CFG_TIMEOUT:    r_timeout    <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    assign w_out_free    = !r_out_valid || o_out.ready;
    assign w_in_ready    = !w_frame_active && w_out_free;
    assign i_in.ready    = w_in_ready;
    assign w_in_acc      = i_in.valid && w_in_ready;
    assign w_frame_start = w_in_acc && w_req.start;
    assign w_emit_load   = w_frame_emit && w_out_free;
    assign w_stat_load   = w_in_acc && !w_req.start;

    msq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_in_acc),
        .i_op         (i_in.op),
        .i_execute    (i_in.execute),
        .i_timeout_ms (r_timeout),
        .o_req        (w_req),
        .o_cur        (w_cur),
        .o_nxt        (w_nxt)
    );

    msq_frame u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_frame_start),
        .i_second     (w_req.second),
        .i_slave_addr (r_slave_addr),
        .i_mode_reg   (r_mode_reg),
        .i_mode_val   (r_mode_val),
        .i_cur_reg    (r_cur_reg),
        .i_cur_val    (r_cur_val),
        .i_out_free   (w_out_free),
        .o_active     (w_frame_active),
        .o_emit       (w_frame_emit),
        .o_byte       (w_frame_byte),
        .o_last       (w_frame_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_load || w_stat_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_load) begin
            r_tx_valid <= 1'b1;
            r_tx_byte  <= w_frame_byte;
            r_run_last <= w_frame_last;
            r_status   <= w_cur;
        end else if (w_stat_load) begin
            r_tx_valid <= 1'b0;
            r_tx_byte  <= 8'h00;
            r_run_last <= 1'b1;
            r_status   <= w_nxt;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.tx_valid   = r_tx_valid;
    assign o_out.tx_byte    = r_tx_byte;
    assign o_out.run_last   = r_run_last;
    assign o_out.busy_res   = r_status.busy;
    assign o_out.done_res   = r_status.done;
    assign o_out.error_code = r_status.error;

    `MSQ_ASSERT_IMPL(a_no_accept_in_frame, i_clk, i_rst_n, w_frame_active, !w_in_acc, "input accepted during frame")
    `MSQ_ASSERT_NEXT(a_frame_starts, i_clk, i_rst_n, w_frame_start, w_frame_active, "frame did not start")
    `MSQ_ASSERT_NEXT(a_frame_ends, i_clk, i_rst_n, w_emit_load && w_frame_last, !w_frame_active, "frame ran past last beat")
    `MSQ_ASSERT_NEXT(a_status_beat, i_clk, i_rst_n, w_stat_load, r_out_valid && r_run_last && !r_tx_valid, "status beat lost")

endmodule

`default_nettype wire
